@@ rtl/core/amspc_pkg.sv @@
package amspc_pkg;

	localparam int MAX_PATTERN_DEF    = 12;
	localparam int COUNT_WIDTH_DEF    = 20;
	localparam int POSITION_WIDTH_DEF = 16;

	localparam int PAT_BASES = 12;
	localparam int CFG_W     = 24;
	localparam int MISM_W    = 5;
	localparam int LEN_MIN   = 6;

	localparam logic [1:0] REG_PATTERN = 2'd0;
	localparam logic [1:0] REG_LENGTH  = 2'd1;
	localparam logic [1:0] REG_MAXMIS  = 2'd2;

	localparam logic FUNC_SEQ  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	typedef struct packed {
		logic shift;
		logic clear;
		logic hit;
	} amspc_cell_ctl_t;

	typedef struct packed {
		logic       bad;
		logic [1:0] code;
	} amspc_base_t;

	function automatic amspc_base_t base_decode(input logic [7:0] ch);
		amspc_base_t r;
		r.bad  = 1'b0;
		r.code = BASE_A;
		if (ch inside {8'h41, 8'h61}) begin
			r.code = BASE_A;
		end else if (ch inside {8'h43, 8'h63}) begin
			r.code = BASE_C;
		end else if (ch inside {8'h47, 8'h67}) begin
			r.code = BASE_G;
		end else if (ch inside {8'h54, 8'h74}) begin
			r.code = BASE_T;
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

endpackage

@@ rtl/core/amspc_cell.sv @@
module amspc_cell
	import amspc_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  amspc_cell_ctl_t                 ctl,
	input  logic [1:0]                      shift_base,
	input  logic                            shift_bad,
	input  logic                            en,
	input  logic [1:0]                      al_base,
	input  logic                            al_bad,
	input  logic [1:0]                      pat_base,
	output logic [1:0]                      slot_base,
	output logic                            slot_bad,
	output logic                            miss,
	output logic                            bad,
	output logic [3:0][COUNT_WIDTH-1:0]     cnt
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic [1:0]                  base_q;
	logic                        bad_q;
	logic [3:0][COUNT_WIDTH-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_A;
			bad_q  <= 1'b1;
		end else if (ctl.shift) begin
			if (ctl.clear) begin
				base_q <= BASE_A;
				bad_q  <= 1'b1;
			end else begin
				base_q <= shift_base;
				bad_q  <= shift_bad;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.hit && en && cnt_q[al_base] != CNT_MAX) begin
			cnt_q[al_base] <= cnt_q[al_base] + 1'b1;
		end
	end

	assign slot_base = base_q;
	assign slot_bad  = bad_q;
	assign miss      = en && (al_base != pat_base);
	assign bad       = en && al_bad;
	assign cnt       = cnt_q;

endmodule

@@ rtl/core/approx_motif_scan_profile_count.sv @@
// An accepted request's result is in the output register in the next cycle.
// Throughput: one request per cycle if not stalled; the window compare, mismatch
//   sum and the per-position counter updates all settle in the accept cycle.
// in_ready is high while the output register is empty or being drained.
// Reset (arst_n low, async): window marked invalid, counts and total cleared,
//   pattern 0, length 6, mismatch limit 0. No clearing pass is needed.
module approx_motif_scan_profile_count
	import amspc_pkg::*;
#(
	parameter int MAX_PATTERN    = MAX_PATTERN_DEF,
	parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      func,
	input  logic [7:0]                seq_char,
	input  logic                      last_in_seq,
	input  logic [3:0]                read_position,
	input  logic [1:0]                read_letter,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      window_valid,
	output logic                      window_match,
	output logic [3:0]                mismatch_count,
	output logic [POSITION_WIDTH-1:0] window_start,
	output logic [COUNT_WIDTH-1:0]    match_total,
	output logic [COUNT_WIDTH-1:0]    count_value
);

	localparam int IDX_W = $clog2(MAX_PATTERN);
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int SEL_W = $clog2(2 * MAX_PATTERN);
	localparam logic [COUNT_WIDTH-1:0]    CNT_MAX = '1;
	localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

	logic [CFG_W-1:0]          pattern_q;
	logic [3:0]                len_q;
	logic [3:0]                maxmm_q;
	logic [POSITION_WIDTH-1:0] chars_q;
	logic [COUNT_WIDTH-1:0]    total_q;

	logic                      ovalid_q;
	logic                      wvalid_q;
	logic                      wmatch_q;
	logic [3:0]                mism_q;
	logic [POSITION_WIDTH-1:0] start_q;
	logic [COUNT_WIDTH-1:0]    cval_q;

	logic                      accept;
	logic                      seq_acc;
	amspc_base_t               dec;
	amspc_cell_ctl_t           ctl;
	logic [LEN_W-1:0]          len_eff;

	logic [MAX_PATTERN-1:0][1:0]              nb_base;
	logic [MAX_PATTERN-1:0]                   nb_bad;
	logic [MAX_PATTERN-1:0][1:0]              slot_base;
	logic [MAX_PATTERN-1:0]                   slot_bad;
	logic [MAX_PATTERN-1:0]                   miss;
	logic [MAX_PATTERN-1:0]                   bad;
	logic [3:0][COUNT_WIDTH-1:0]              cnt_rows [MAX_PATTERN];

	logic                      win_ok;
	logic [MISM_W-1:0]         mism;
	logic                      hit;
	logic [POSITION_WIDTH-1:0] chars_next;
	logic [POSITION_WIDTH-1:0] start;
	logic [COUNT_WIDTH-1:0]    rd_val;

	assign in_ready = !ovalid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign seq_acc  = accept && (func == FUNC_SEQ);
	assign dec      = base_decode(seq_char);

	always_comb begin
		if (len_q < 4'(LEN_MIN)) begin
			len_eff = LEN_W'(LEN_MIN);
		end else if (32'(len_q) > MAX_PATTERN) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = LEN_W'(len_q);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_PATTERN - 1; i++) begin
			nb_base[i] = slot_base[i+1];
			nb_bad[i]  = slot_bad[i+1];
		end
		nb_base[MAX_PATTERN-1] = dec.code;
		nb_bad[MAX_PATTERN-1]  = dec.bad;
	end

	for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
		logic             en;
		logic [SEL_W-1:0] sel;
		logic [1:0]       al_base;
		logic             al_bad;
		logic [1:0]       pat_base;

		assign en  = 32'(len_eff) > g;
		assign sel = SEL_W'(MAX_PATTERN + g) - SEL_W'(len_eff);
		assign al_base = en ? nb_base[sel[IDX_W-1:0]] : BASE_A;
		assign al_bad  = en ? nb_bad[sel[IDX_W-1:0]] : 1'b0;

		if (g < PAT_BASES) begin : g_pat
			assign pat_base = pattern_q[2*g +: 2];
		end else begin : g_nopat
			assign pat_base = BASE_A;
		end

		amspc_cell #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.shift_base (nb_base[g]),
			.shift_bad  (nb_bad[g]),
			.en         (en),
			.al_base    (al_base),
			.al_bad     (al_bad),
			.pat_base   (pat_base),
			.slot_base  (slot_base[g]),
			.slot_bad   (slot_bad[g]),
			.miss       (miss[g]),
			.bad        (bad[g]),
			.cnt        (cnt_rows[g])
		);
	end

	always_comb begin
		mism = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			mism = mism + MISM_W'(miss[i]);
		end
	end

	assign win_ok     = ~|bad;
	assign hit        = seq_acc && win_ok && (mism <= MISM_W'(maxmm_q));
	assign chars_next = (chars_q != POS_MAX) ? chars_q + 1'b1 : chars_q;
	assign start      = (chars_next >= POSITION_WIDTH'(len_eff))
		? chars_next - POSITION_WIDTH'(len_eff) : '0;

	assign ctl.shift = seq_acc;
	assign ctl.clear = last_in_seq;
	assign ctl.hit   = hit;

	assign rd_val = (32'(read_position) < MAX_PATTERN)
		? cnt_rows[read_position[IDX_W-1:0]][read_letter] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			len_q     <= 4'(LEN_MIN);
			maxmm_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN: pattern_q <= cfg_data;
				REG_LENGTH:  len_q     <= cfg_data[3:0];
				REG_MAXMIS:  maxmm_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_q <= '0;
			total_q <= '0;
		end else begin
			if (seq_acc) begin
				chars_q <= last_in_seq ? '0 : chars_next;
			end
			if (hit && total_q != CNT_MAX) begin
				total_q <= total_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (accept) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (func == FUNC_SEQ) begin
				wvalid_q <= win_ok;
				wmatch_q <= hit;
				mism_q   <= !win_ok ? 4'd0 : (mism > MISM_W'(15)) ? 4'hF : mism[3:0];
				start_q  <= win_ok ? start : '0;
				cval_q   <= '0;
			end else begin
				wvalid_q <= 1'b0;
				wmatch_q <= 1'b0;
				mism_q   <= '0;
				start_q  <= '0;
				cval_q   <= rd_val;
			end
		end
	end

	assign out_valid      = ovalid_q;
	assign window_valid   = wvalid_q;
	assign window_match   = wmatch_q;
	assign mismatch_count = mism_q;
	assign window_start   = start_q;
	assign match_total    = total_q;
	assign count_value    = cval_q;

endmodule

@@ rtl/core/amspc_checker.sv @@
module amspc_checker
	import amspc_pkg::*;
#(
	parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      window_valid,
	input logic                      window_match,
	input logic [3:0]                mismatch_count,
	input logic [POSITION_WIDTH-1:0] window_start,
	input logic [COUNT_WIDTH-1:0]    match_total,
	input logic [COUNT_WIDTH-1:0]    count_value
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(window_valid)
			&& $stable(window_match) && $stable(mismatch_count)
			&& $stable(window_start) && $stable(match_total) && $stable(count_value))
		else $error("result changed while stalled");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output register");

	a_match_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && window_match |-> window_valid)
		else $error("match on a rejected window");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !window_valid |-> mismatch_count == 4'd0 && window_start == '0)
		else $error("window fields set without a valid window");

endmodule

bind approx_motif_scan_profile_count amspc_checker #(
	.COUNT_WIDTH    (COUNT_WIDTH),
	.POSITION_WIDTH (POSITION_WIDTH)
) u_amspc_checker (.*);
